// File: rtl/sliding_window_maximum_unit_macros.svh
// Assertion macros for the sliding window maximum unit.
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/swm_pkg.sv
// Shared constants, payload types and helpers of the sliding window maximum unit.
package swm_pkg;

  localparam int unsigned MaxWindow  = 64;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned IdxW       = $clog2(MaxWindow);
  localparam int unsigned CntW       = $clog2(MaxWindow + 1);
  localparam int unsigned CfgW       = 7;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;

  localparam logic [CfgW-1:0] WindowReset = CfgW'(3);
  localparam logic            RegWindowIdx = 1'b0;

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    stream_end;
  } swm_in_t;

  typedef struct packed {
    sample_t window_max;
    logic    final_res;
  } swm_out_t;

  typedef struct packed {
    logic shift;
    logic start;
  } cell_ctrl_t;

  function automatic logic [CntW-1:0] eff_window(logic [CfgW-1:0] v);
    logic [CntW-1:0] r;
    if (v == '0) begin
      r = CntW'(1);
    end else if (32'(v) > MaxWindow) begin
      r = CntW'(MaxWindow);
    end else begin
      r = CntW'(v);
    end
    return r;
  endfunction

endpackage

// File: rtl/swm_cell.sv
// One cell of the chain: holds the maximum of the newest samples up to its depth.
module swm_cell
  import swm_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  sample_t    sample_i,
  input  sample_t    prev_max_i,
  output sample_t    max_o
);

  sample_t max_q;
  sample_t max_d;

  always_comb begin
    if (ctrl_i.start || (sample_i >= prev_max_i)) begin
      max_d = sample_i;
    end else begin
      max_d = prev_max_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

// File: rtl/swm_regs.sv
// Configuration register block with APB-style access.
module swm_regs
  import swm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic             cfg_wr_o,
  output logic [CfgW-1:0]  window_size_o
);

  logic [CfgW-1:0] window_q;
  logic            hit;

  assign pready   = 1'b1;
  assign hit      = (paddr[AddrW-1:2] == RegWindowIdx);
  assign cfg_wr_o = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_wr_o) begin
      window_q <= pwdata[CfgW-1:0];
    end
  end

  assign prdata        = hit ? DataW'(window_q) : '0;
  assign window_size_o = window_q;

endmodule

// File: rtl/sliding_window_maximum_unit.sv
// Top level of the sliding window maximum unit: cell chain, stream control, output stage.
//
//   port group   direction  handshake                  payload
//   in_*         input      in_valid_i / in_ready_o    in_data_i  (swm_in_t)
//   out_*        output     out_valid_o / out_ready_i  out_data_o (swm_out_t)
//   APB          in/out     psel, penable, pwrite      paddr, pwdata, prdata
//
// One sample per clock while in_ready_o is high; a result is registered in the cells, then in the output stage.
// Cells past the head compare the neighbor's maximum with the broadcast sample in parallel.
// Reset clears the stream count and the output stage and sets the window to 3.
// A result held at the output stalls intake only once a second result is pending.
`include "sliding_window_maximum_unit_macros.svh"

module sliding_window_maximum_unit
  import swm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  swm_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output swm_out_t         out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic            cfg_wr;
  logic [CfgW-1:0] window_size;
  logic [CntW-1:0] w_eff;

  logic [CntW-1:0] seen_q;
  logic [CntW-1:0] seen_d;
  logic [CntW-1:0] seen_inc;
  logic            pend_q;
  logic [IdxW-1:0] sel_q;
  logic [CntW-1:0] sel_full;
  logic            last_q;
  logic            out_valid_q;
  swm_out_t        out_data_q;

  logic            in_fire;
  logic            load_out;
  logic            emit;
  cell_ctrl_t      ctrl;
  sample_t         cell_max [MaxWindow];

  swm_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cfg_wr_o      (cfg_wr),
    .window_size_o (window_size)
  );

  assign w_eff = eff_window(window_size);

  assign load_out   = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || load_out;
  assign in_fire    = in_valid_i && in_ready_o;

  assign seen_inc = (seen_q < w_eff) ? seen_q + CntW'(1) : seen_q;
  assign emit     = (seen_inc >= w_eff) || in_data_i.stream_end;
  assign sel_full = seen_inc - CntW'(1);
  assign seen_d   = in_data_i.stream_end ? '0 : seen_inc;

  assign ctrl.shift = in_fire;
  assign ctrl.start = (seen_q == '0);

  for (genvar k = 0; k < MaxWindow; k++) begin : g_cell
    if (k == 0) begin : g_head
      swm_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .sample_i   (in_data_i.sample),
        .prev_max_i (in_data_i.sample),
        .max_o      (cell_max[k])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .sample_i   (in_data_i.sample),
        .prev_max_i (cell_max[k-1]),
        .max_o      (cell_max[k])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        seen_q <= '0;
      end else if (in_fire) begin
        seen_q <= seen_d;
      end
      if (in_fire) begin
        pend_q <= emit;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sel_q  <= sel_full[IdxW-1:0];
      last_q <= in_data_i.stream_end;
    end
    if (load_out) begin
      out_data_q.window_max <= cell_max[sel_q];
      out_data_q.final_res  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SWM_ASSERT_SAME(a_stall_when_full, pend_q && out_valid_q && !out_ready_i, !in_ready_o,
    "intake open while a result is pending behind a stalled output")
  `SWM_ASSERT_SAME(a_seen_bounded, 1'b1, seen_q <= w_eff,
    "sample count exceeds the window")
  `SWM_ASSERT_NEXT(a_end_clears, in_fire && in_data_i.stream_end, seen_q == '0,
    "stream state not cleared after the last sample")
  `SWM_ASSERT_NEXT(a_pend_moves, load_out && !in_fire, !pend_q && out_valid_q,
    "pending result not moved to the output stage")

endmodule
